FILE: design/trs_pkg.sv
package trs_pkg;

  localparam int VALUE_FRAC_BITS = 16;
  localparam int ANGLE_FRAC_BITS = 20;
  localparam int XW = 33;   // CORDIC x/y, Q.30
  localparam int ZW = 35;   // CORDIC angle, Q.30
  localparam int SCW = 18;  // sine/cosine, +-1.0 in Q16
  localparam int TW = 20;   // rotation product elements
  localparam int NUM_ROWS = 4;

  localparam logic signed [ZW-1:0] Q30_PI = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI = 35'sd6746518852;
  localparam logic signed [XW-1:0] Q30_GAIN = 33'sd652032874;
  localparam logic signed [SCW-1:0] ONE_Q = SCW'(1 << VALUE_FRAC_BITS);
  localparam logic [1:0] LAST_ROW_IDX = 2'(NUM_ROWS - 1);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic neg;
    logic zero;
  } lane_t;

  typedef struct packed {
    logic valid;
    lane_t [2:0] lane;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] scl;
  } stage_t;

  typedef struct packed {
    logic valid;
    logic [2:0][2:0][31:0] elem;
    logic [2:0][31:0] pos;
  } mat_t;

  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] r;
    case (i)
      0: r = 31'd843314857;
      1: r = 31'd497837830;
      2: r = 31'd263043837;
      3: r = 31'd133525159;
      4: r = 31'd67021687;
      5: r = 31'd33543516;
      6: r = 31'd16775851;
      7: r = 31'd8388437;
      8: r = 31'd4194283;
      9: r = 31'd2097149;
      default: r = (i < 30) ? 31'(1 << (30 - i)) : 31'd0;
    endcase
    return r;
  endfunction

  // round half away from zero
  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

FILE: design/trs_if.sv
interface trs_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [22:0] angle_x;
  logic signed [22:0] angle_y;
  logic signed [22:0] angle_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_out_if;
  logic valid;
  logic ready;
  logic [1:0] row_index;
  logic last_row;
  logic signed [31:0] elem_c0;
  logic signed [31:0] elem_c1;
  logic signed [31:0] elem_c2;
  logic signed [31:0] elem_c3;
  modport source (output valid, row_index, last_row, elem_c0, elem_c1, elem_c2, elem_c3,
                  input ready);
  modport sink (input valid, row_index, last_row, elem_c0, elem_c1, elem_c2, elem_c3,
                output ready);
endinterface

FILE: design/trs_transform_matrix_builder.sv
// Pipeline: an input transfer passes one register of angle folding, one per CORDIC
// cell, four for rounding, rotation products and scaling, and one at the row output
// before the first row leaves; then one row per cycle while result.ready is high.
// A new item is taken only when the row output is empty or its last row leaves.
// Reset (synchronous) clears every stage valid flag and the row counter.
module trs_transform_matrix_builder #(
  parameter int CORDIC_STEPS = 20
) (
  input logic clk,
  input logic rst,
  trs_in_if.sink item,
  trs_out_if.source result
);

  trs_pkg::stage_t st [CORDIC_STEPS+1];
  trs_pkg::stage_t st0_next;
  trs_pkg::mat_t mat;
  trs_pkg::mat_t hold;
  logic hold_valid;
  logic [1:0] cnt;
  logic adv;

  assign adv = !hold_valid || (result.ready && cnt == trs_pkg::LAST_ROW_IDX);
  assign item.ready = adv;

  // angle to Q.30, wrap into [-pi, pi], fold into [-pi/2, pi/2]
  always_comb begin
    logic signed [22:0] ang [3];
    logic signed [trs_pkg::ZW-1:0] z;
    ang[0] = item.angle_x;
    ang[1] = item.angle_y;
    ang[2] = item.angle_z;
    st0_next.valid = item.valid;
    st0_next.pos = {item.pos_z, item.pos_y, item.pos_x};
    st0_next.scl = {item.scale_z, item.scale_y, item.scale_x};
    for (int a = 0; a < 3; a++) begin
      z = trs_pkg::ZW'(ang[a]) <<< (30 - trs_pkg::ANGLE_FRAC_BITS);
      if (z > trs_pkg::Q30_PI) z = z - trs_pkg::Q30_TWO_PI;
      else if (z < -trs_pkg::Q30_PI) z = z + trs_pkg::Q30_TWO_PI;
      st0_next.lane[a].neg = 1'b0;
      if (z > trs_pkg::Q30_HALF_PI) begin
        z = z - trs_pkg::Q30_PI;
        st0_next.lane[a].neg = 1'b1;
      end else if (z < -trs_pkg::Q30_HALF_PI) begin
        z = z + trs_pkg::Q30_PI;
        st0_next.lane[a].neg = 1'b1;
      end
      st0_next.lane[a].x = trs_pkg::Q30_GAIN;
      st0_next.lane[a].y = '0;
      st0_next.lane[a].z = z;
      st0_next.lane[a].zero = (ang[a] == 23'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st[0].valid <= 1'b0;
    else if (adv) st[0] <= st0_next;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    trs_cordic_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .din(st[k]), .dout(st[k+1])
    );
  end

  trs_matrix u_matrix (
    .clk(clk), .rst(rst), .adv(adv), .din(st[CORDIC_STEPS]), .dout(mat)
  );

  // row output: holds one matrix and sends it as four rows
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt <= '0;
    end else if (adv) begin
      hold <= mat;
      hold_valid <= mat.valid;
      cnt <= '0;
    end else if (result.ready) begin
      cnt <= cnt + 2'd1;
    end
  end

  assign result.valid = hold_valid;
  assign result.row_index = cnt;
  assign result.last_row = (cnt == trs_pkg::LAST_ROW_IDX);

  always_comb begin
    case (cnt)
      2'd0, 2'd1, 2'd2: begin
        result.elem_c0 = hold.elem[cnt][0];
        result.elem_c1 = hold.elem[cnt][1];
        result.elem_c2 = hold.elem[cnt][2];
        result.elem_c3 = hold.pos[cnt];
      end
      default: begin
        result.elem_c0 = '0;
        result.elem_c1 = '0;
        result.elem_c2 = '0;
        result.elem_c3 = 32'(trs_pkg::ONE_Q);
      end
    endcase
  end

endmodule

FILE: design/trs_cordic_cell.sv
module trs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  trs_pkg::stage_t din,
  output trs_pkg::stage_t dout
);

  localparam logic signed [trs_pkg::ZW-1:0] ATAN =
    signed'(trs_pkg::ZW'(trs_pkg::atan_q30(STEP)));

  trs_pkg::stage_t dout_next;

  always_comb begin
    dout_next = din;
    for (int a = 0; a < 3; a++) begin
      if (din.lane[a].z >= 0) begin
        dout_next.lane[a].x = din.lane[a].x - (din.lane[a].y >>> STEP);
        dout_next.lane[a].y = din.lane[a].y + (din.lane[a].x >>> STEP);
        dout_next.lane[a].z = din.lane[a].z - ATAN;
      end else begin
        dout_next.lane[a].x = din.lane[a].x + (din.lane[a].y >>> STEP);
        dout_next.lane[a].y = din.lane[a].y - (din.lane[a].x >>> STEP);
        dout_next.lane[a].z = din.lane[a].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (adv) dout <= dout_next;
  end

endmodule

FILE: design/trs_matrix.sv
module trs_matrix (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  trs_pkg::stage_t din,
  output trs_pkg::mat_t dout
);

  localparam int SH = 30 - trs_pkg::VALUE_FRAC_BITS;
  localparam int VF = trs_pkg::VALUE_FRAC_BITS;

  // sine/cosine stage
  logic sc_valid;
  logic signed [trs_pkg::SCW-1:0] c [3];
  logic signed [trs_pkg::SCW-1:0] s [3];
  logic [2:0][31:0] sc_pos, sc_scl;
  logic signed [trs_pkg::SCW-1:0] c_next [3];
  logic signed [trs_pkg::SCW-1:0] s_next [3];

  always_comb begin
    logic signed [trs_pkg::XW-1:0] xv, yv;
    logic signed [63:0] rc, rs;
    for (int a = 0; a < 3; a++) begin
      xv = din.lane[a].neg ? -din.lane[a].x : din.lane[a].x;
      yv = din.lane[a].neg ? -din.lane[a].y : din.lane[a].y;
      rc = trs_pkg::round_sh(64'(xv), SH);
      rs = trs_pkg::round_sh(64'(yv), SH);
      if (rc > 64'(trs_pkg::ONE_Q)) rc = 64'(trs_pkg::ONE_Q);
      if (rc < -64'(trs_pkg::ONE_Q)) rc = -64'(trs_pkg::ONE_Q);
      if (rs > 64'(trs_pkg::ONE_Q)) rs = 64'(trs_pkg::ONE_Q);
      if (rs < -64'(trs_pkg::ONE_Q)) rs = -64'(trs_pkg::ONE_Q);
      if (din.lane[a].zero) begin
        rc = 64'(trs_pkg::ONE_Q);
        rs = '0;
      end
      c_next[a] = rc[trs_pkg::SCW-1:0];
      s_next[a] = rs[trs_pkg::SCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (adv) begin
      sc_valid <= din.valid;
      c <= c_next;
      s <= s_next;
      sc_pos <= din.pos;
      sc_scl <= din.scl;
    end
  end

  // Rx*Ry stage
  logic t_valid;
  logic signed [trs_pkg::TW-1:0] t [3][3];
  logic signed [trs_pkg::TW-1:0] t_next [3][3];
  logic signed [trs_pkg::SCW-1:0] cz, sz;
  logic [2:0][31:0] t_pos, t_scl;

  always_comb begin
    logic signed [35:0] p_sxsy, p_sxcy, p_cxsy, p_cxcy;
    logic signed [63:0] r0, r1, r2, r3;
    p_sxsy = s[0] * s[1];
    p_sxcy = s[0] * c[1];
    p_cxsy = c[0] * s[1];
    p_cxcy = c[0] * c[1];
    r0 = trs_pkg::round_sh(64'(p_sxsy), VF);
    r1 = trs_pkg::round_sh(64'(p_sxcy), VF);
    r2 = trs_pkg::round_sh(64'(p_cxsy), VF);
    r3 = trs_pkg::round_sh(64'(p_cxcy), VF);
    t_next[0][0] = trs_pkg::TW'(c[1]);
    t_next[0][1] = '0;
    t_next[0][2] = trs_pkg::TW'(s[1]);
    t_next[1][0] = r0[trs_pkg::TW-1:0];
    t_next[1][1] = trs_pkg::TW'(c[0]);
    t_next[1][2] = -r1[trs_pkg::TW-1:0];
    t_next[2][0] = -r2[trs_pkg::TW-1:0];
    t_next[2][1] = trs_pkg::TW'(s[0]);
    t_next[2][2] = r3[trs_pkg::TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= sc_valid;
      t <= t_next;
      cz <= c[2];
      sz <= s[2];
      t_pos <= sc_pos;
      t_scl <= sc_scl;
    end
  end

  // (Rx*Ry)*Rz stage
  logic m_valid;
  logic signed [trs_pkg::TW-1:0] m [3][3];
  logic signed [trs_pkg::TW-1:0] m_next [3][3];
  logic [2:0][31:0] m_pos, m_scl;

  always_comb begin
    logic signed [38:0] a0, a1;
    logic signed [63:0] r0, r1;
    for (int i = 0; i < 3; i++) begin
      a0 = 39'(t[i][0] * cz) + 39'(t[i][1] * sz);
      a1 = 39'(t[i][1] * cz) - 39'(t[i][0] * sz);
      r0 = trs_pkg::round_sh(64'(a0), VF);
      r1 = trs_pkg::round_sh(64'(a1), VF);
      m_next[i][0] = r0[trs_pkg::TW-1:0];
      m_next[i][1] = r1[trs_pkg::TW-1:0];
      m_next[i][2] = t[i][2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= t_valid;
      m <= m_next;
      m_pos <= t_pos;
      m_scl <= t_scl;
    end
  end

  // column scaling
  trs_pkg::mat_t dout_next;

  always_comb begin
    logic signed [51:0] p;
    dout_next.valid = m_valid;
    dout_next.pos = m_pos;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = 52'(m[i][j] * $signed(m_scl[j]));
        dout_next.elem[i][j] = trs_pkg::sat32(trs_pkg::round_sh(64'(p), VF));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (adv) dout <= dout_next;
  end

endmodule

FILE: design/trs_checker.sv
module trs_checker (
  input logic clk,
  input logic rst,
  input logic o_valid,
  input logic o_ready,
  input logic [1:0] o_row,
  input logic o_last,
  input logic [31:0] o_c0,
  input logic [31:0] o_c1,
  input logic [31:0] o_c2,
  input logic [31:0] o_c3
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !o_valid)
    else $error("result valid after reset");

  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_ready && !o_last |=> o_valid && o_row == $past(o_row) + 2'd1)
    else $error("row sequence broken");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_last == (o_row == 2'd3)))
    else $error("last_row mismatch");

  a_bottom_row: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_last |-> o_c0 == 32'd0 && o_c1 == 32'd0 && o_c2 == 32'd0
                          && o_c3 == 32'h0001_0000)
    else $error("bottom row not 0,0,0,1");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_row) && $stable(o_c0) && $stable(o_c3))
    else $error("stalled result changed");

endmodule

bind trs_transform_matrix_builder trs_checker u_trs_checker (
  .clk(clk), .rst(rst),
  .o_valid(result.valid), .o_ready(result.ready), .o_row(result.row_index),
  .o_last(result.last_row), .o_c0(result.elem_c0), .o_c1(result.elem_c1),
  .o_c2(result.elem_c2), .o_c3(result.elem_c3)
);
